// ===== rtl/gwc_pkg.sv =====
`default_nettype none

package gwc_pkg;

   // field widths
   localparam int INTENSITY_W    = 16;
   localparam int DISTANCE_W     = 16;
   localparam int WEIGHT_W       = 16;
   localparam int INV_SIGMA_SQ_W = 24;
   localparam int COMPOUNDED_W   = 16;

   // set size and weight table
   localparam int MAX_SAMPLES        = 1024;
   localparam int WEIGHT_TABLE_DEPTH = 1024;
   localparam int IDX_W              = $clog2(WEIGHT_TABLE_DEPTH);

   // distance squared is q16.16, x = d2 * inv_sigma_sq carries 32 fraction bits
   localparam int D2_W      = 2 * DISTANCE_W;
   localparam int X_W       = D2_W + INV_SIGMA_SQ_W;
   localparam int X_FRAC_W  = 32;
   localparam int X_LIMIT_B = X_FRAC_W + 4;

   // accumulators
   localparam int COUNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int PRODUCT_W = INTENSITY_W + WEIGHT_W;
   localparam int WSUM_W    = PRODUCT_W + $clog2(MAX_SAMPLES);
   localparam int DEN_W     = WEIGHT_W + $clog2(MAX_SAMPLES) + 1;

   // divider: rounded numerator, quotient bits
   localparam int NUMR_W = WSUM_W + 1;
   localparam int Q_W    = COMPOUNDED_W;
   localparam int STEP_W = $clog2(Q_W);

   // queue of closed sets between front and back
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
   // items that may still be on their way into the queue (front stages plus the new one)
   localparam int IN_FLIGHT   = 6;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = INV_SIGMA_SQ_W;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE         = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_INV_SIGMA_SQ = 1'b1;
   localparam logic [INV_SIGMA_SQ_W-1:0] INV_SIGMA_SQ_RESET = 24'h01_0000;

   localparam logic MODE_GAUSSIAN = 1'b0;
   localparam logic MODE_MEAN     = 1'b1;

   typedef logic [WEIGHT_W-1:0] weight_rom_type [WEIGHT_TABLE_DEPTH];

   typedef struct packed {
      logic [WSUM_W-1:0] num;
      logic [DEN_W-1:0]  den;
      logic              overflow;
   } close_type;

   typedef struct packed {
      logic      valid;
      close_type entry;
   } push_type;

   typedef struct packed {
      logic                not_empty;
      logic [QCOUNT_W-1:0] level;
   } queue_status_type;

   // exp(-16*i/depth) in q0.16: taylor series of exp(-x/256), squared eight times
   function automatic weight_rom_type weight_rom_init();
      weight_rom_type rom;
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] w;
      for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++) begin
         y    = (64'(i) << 31) >> (4 + IDX_W);
         term = 64'h8000_0000;
         s    = 64'h8000_0000;
         for (int k = 1; k <= 8; k++) begin
            term = ((term * y) >> 31) / 64'(k);
            if ((k & 1) != 0) begin
               s = s - term;
            end else begin
               s = s + term;
            end
         end
         for (int n = 0; n < 8; n++) begin
            s = (s * s + 64'h4000_0000) >> 31;
         end
         w = (s + 64'h4000) >> 15;
         rom[i] = (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gwc_if.sv =====
`default_nettype none

interface gwc_req_if;
   import gwc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [INTENSITY_W-1:0] intensity;
   logic [DISTANCE_W-1:0]  distance;
   logic                   no_sample;
   logic                   last;

   modport source (output valid, output intensity, output distance, output no_sample,
                   output last, input ready);
   modport sink   (input valid, input intensity, input distance, input no_sample,
                   input last, output ready);
endinterface

interface gwc_rsp_if;
   import gwc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [COMPOUNDED_W-1:0] compounded;
   logic                    empty_set;
   logic                    overflow;

   modport source (output valid, output compounded, output empty_set, output overflow,
                   input ready);
   modport sink   (input valid, input compounded, input empty_set, input overflow,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/gwc_front.sv =====
`default_nettype none

module gwc_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   gwc_req_if.sink                                     req,
   input  wire logic                                   mode,
   input  wire logic [gwc_pkg::INV_SIGMA_SQ_W-1:0]     inv_sigma_sq,
   input  wire gwc_pkg::queue_status_type              queue_status,
   output gwc_pkg::push_type                           close_push
);
   import gwc_pkg::*;

   localparam weight_rom_type WEIGHT_ROM = weight_rom_init();

   logic accept;

   // stage 1: captured item
   logic                   s1_valid_ff, s1_no_sample_ff, s1_last_ff;
   logic [INTENSITY_W-1:0] s1_intensity_ff;
   logic [DISTANCE_W-1:0]  s1_distance_ff;
   // stage 2: distance squared
   logic                   s2_valid_ff, s2_no_sample_ff, s2_last_ff;
   logic [INTENSITY_W-1:0] s2_intensity_ff;
   logic [D2_W-1:0]        s2_d2_ff;
   // stage 3: scaled table coordinate
   logic                   s3_valid_ff, s3_no_sample_ff, s3_last_ff;
   logic [INTENSITY_W-1:0] s3_intensity_ff;
   logic [X_W-1:0]         s3_x_ff;
   // stage 4: weight
   logic                   s4_valid_ff, s4_no_sample_ff, s4_last_ff;
   logic [INTENSITY_W-1:0] s4_intensity_ff;
   logic [WEIGHT_W-1:0]    s4_weight_ff;
   // stage 5: weighted intensity
   logic                   s5_valid_ff, s5_no_sample_ff, s5_last_ff;
   logic [INTENSITY_W-1:0] s5_intensity_ff;
   logic [WEIGHT_W-1:0]    s5_weight_ff;
   logic [PRODUCT_W-1:0]   s5_product_ff;

   // set accumulators
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [DEN_W-1:0]   wtsum_ff, wtsum_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               ovf_ff, ovf_in;

   logic                wsum_add, wtsum_add, count_add, ovf_add;
   logic [WSUM_W-1:0]   wsum_sum;
   logic [DEN_W-1:0]    wtsum_sum;
   logic [COUNT_W-1:0]  count_sum;
   logic                take;
   logic                beyond;
   logic [IDX_W-1:0]    rom_idx;

   // room must remain for every closing item that could still be on its way
   assign req.ready = (queue_status.level <= QCOUNT_W'(QUEUE_DEPTH - IN_FLIGHT));
   assign accept    = req.valid && req.ready;

   // weight is zero at or beyond x = 16
   assign beyond  = |s3_x_ff[X_W-1:X_LIMIT_B];
   assign rom_idx = s3_x_ff[X_LIMIT_B-1 -: IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_intensity_ff <= req.intensity;
      s1_distance_ff  <= req.distance;
      s1_no_sample_ff <= req.no_sample;
      s1_last_ff      <= req.last;

      s2_intensity_ff <= s1_intensity_ff;
      s2_no_sample_ff <= s1_no_sample_ff;
      s2_last_ff      <= s1_last_ff;
      s2_d2_ff        <= D2_W'(s1_distance_ff) * D2_W'(s1_distance_ff);

      s3_intensity_ff <= s2_intensity_ff;
      s3_no_sample_ff <= s2_no_sample_ff;
      s3_last_ff      <= s2_last_ff;
      s3_x_ff         <= X_W'(s2_d2_ff) * X_W'(inv_sigma_sq);

      s4_intensity_ff <= s3_intensity_ff;
      s4_no_sample_ff <= s3_no_sample_ff;
      s4_last_ff      <= s3_last_ff;
      s4_weight_ff    <= beyond ? '0 : WEIGHT_ROM[rom_idx];

      s5_intensity_ff <= s4_intensity_ff;
      s5_no_sample_ff <= s4_no_sample_ff;
      s5_last_ff      <= s4_last_ff;
      s5_weight_ff    <= s4_weight_ff;
      s5_product_ff   <= PRODUCT_W'(s4_intensity_ff) * PRODUCT_W'(s4_weight_ff);
   end

   // accumulate, drop samples past the limit
   always_comb begin
      take      = s5_valid_ff && !s5_no_sample_ff;
      ovf_add   = take && (count_ff >= COUNT_W'(MAX_SAMPLES));
      count_add = take && !ovf_add;
      wsum_add  = count_add;
      wtsum_add = count_add && (mode == MODE_GAUSSIAN);

      wsum_sum  = wsum_ff + ((mode == MODE_MEAN) ? WSUM_W'(s5_intensity_ff)
                                                 : WSUM_W'(s5_product_ff));
      wtsum_sum = wtsum_ff + DEN_W'(s5_weight_ff);
      count_sum = count_ff + COUNT_W'(1);

      wsum_in  = wsum_add  ? wsum_sum  : wsum_ff;
      wtsum_in = wtsum_add ? wtsum_sum : wtsum_ff;
      count_in = count_add ? count_sum : count_ff;
      ovf_in   = ovf_ff || ovf_add;

      close_push.valid          = s5_valid_ff && s5_last_ff;
      close_push.entry.num      = wsum_in;
      close_push.entry.den      = (mode == MODE_MEAN) ? DEN_W'(count_in) : wtsum_in;
      close_push.entry.overflow = ovf_in;

      if (close_push.valid) begin
         wsum_in  = '0;
         wtsum_in = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff  <= '0;
         wtsum_ff <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         wsum_ff  <= wsum_in;
         wtsum_ff <= wtsum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_SAMPLES))
      else $error("sample count past limit");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      close_push.valid |=> (count_ff == '0) && (wsum_ff == '0) && !ovf_ff)
      else $error("accumulators not cleared after close");

endmodule

`default_nettype wire

// ===== rtl/gwc_queue.sv =====
`default_nettype none

module gwc_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire gwc_pkg::push_type          close_push,
   input  wire logic                       pop,
   output gwc_pkg::queue_status_type       queue_status,
   output gwc_pkg::close_type              head
);
   import gwc_pkg::*;

   close_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCOUNT_W-1:0] count_ff;

   assign queue_status.not_empty = (count_ff != '0);
   assign queue_status.level     = count_ff;
   assign head                   = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (close_push.valid) begin
         entries_ff[wr_ptr_ff] <= close_push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (close_push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCOUNT_W'(close_push.valid) - QCOUNT_W'(pop);
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      close_push.valid |-> (count_ff < QCOUNT_W'(QUEUE_DEPTH)))
      else $error("queue overrun");

   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue underrun");

endmodule

`default_nettype wire

// ===== rtl/gwc_back.sv =====
`default_nettype none

module gwc_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire gwc_pkg::queue_status_type  queue_status,
   input  wire gwc_pkg::close_type         head,
   output logic                            pop,
   gwc_rsp_if.source                       rsp
);
   import gwc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [NUMR_W-1:0] numr_ff, numr_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              ovf_ff, ovf_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [Q_W-1:0]    res_q_ff, res_q_in;
   logic              res_empty_ff, res_empty_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COMPOUNDED_W-1:0] rsp_compounded_ff, rsp_compounded_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic [DEN_W:0] partial, diff;
   logic           fits;
   logic [Q_W-1:0] quo_shift;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.compounded = rsp_compounded_ff;
   assign rsp.empty_set  = rsp_empty_ff;
   assign rsp.overflow   = rsp_ovf_ff;

   // one restoring step per cycle
   assign partial   = {rem_ff, quo_ff[Q_W-1]};
   assign diff      = partial - {1'b0, den_ff};
   assign fits      = (partial >= {1'b0, den_ff});
   assign quo_shift = {quo_ff[Q_W-2:0], fits};

   always_comb begin
      state_in          = state_ff;
      numr_in           = numr_ff;
      den_in            = den_ff;
      ovf_in            = ovf_ff;
      rem_in            = rem_ff;
      quo_in            = quo_ff;
      step_in           = step_ff;
      res_q_in          = res_q_ff;
      res_empty_in      = res_empty_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp.ready;
      rsp_compounded_in = rsp_compounded_ff;
      rsp_empty_in      = rsp_empty_ff;
      rsp_ovf_in        = rsp_ovf_ff;
      pop               = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (queue_status.not_empty) begin
               pop      = 1'b1;
               // add half the denominator for round-half-up
               numr_in  = NUMR_W'(head.num) + NUMR_W'(head.den >> 1);
               den_in   = head.den;
               ovf_in   = head.overflow;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (den_ff == '0) begin
               res_q_in     = '0;
               res_empty_in = 1'b1;
               state_in     = ST_DONE;
            end else if (numr_ff >= {den_ff, Q_W'(0)}) begin
               res_q_in     = '1;
               res_empty_in = 1'b0;
               state_in     = ST_DONE;
            end else begin
               rem_in   = numr_ff[NUMR_W-1:Q_W];
               quo_in   = numr_ff[Q_W-1:0];
               step_in  = STEP_W'(Q_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            quo_in  = quo_shift;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               res_q_in     = quo_shift;
               res_empty_in = 1'b0;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in      = 1'b1;
               rsp_compounded_in = res_q_ff;
               rsp_empty_in      = res_empty_ff;
               rsp_ovf_in        = ovf_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      numr_ff           <= numr_in;
      den_ff            <= den_in;
      ovf_ff            <= ovf_in;
      rem_ff            <= rem_in;
      quo_ff            <= quo_in;
      step_ff           <= step_in;
      res_q_ff          <= res_q_in;
      res_empty_ff      <= res_empty_in;
      rsp_compounded_ff <= rsp_compounded_in;
      rsp_empty_ff      <= rsp_empty_in;
      rsp_ovf_ff        <= rsp_ovf_in;
   end

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_CHECK))
      else $error("set taken outside idle");

endmodule

`default_nettype wire

// ===== rtl/gaussian_weighted_compounding_unit.sv =====
`default_nettype none

// path: a closing item passes 5 front stages, the queue, the range check, the divider
//   and the output register before its result appears
// throughput: one item per cycle while fewer than three closed sets wait in the queue;
//   one set at a time in the shared one-bit-per-cycle divider, popped only when idle
// reset: synchronous, active high; clears accumulators, queue and divider, loads
//   mode 0 and inv_sigma_sq 1.0; the weight table is constant and needs no fill
module gaussian_weighted_compounding_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   gwc_req_if.sink                                  req,
   gwc_rsp_if.source                                rsp,
   input  wire logic                                csr_write_enable,
   input  wire logic [gwc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [gwc_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import gwc_pkg::*;

   // configuration registers
   logic                      mode_ff, mode_in;
   logic [INV_SIGMA_SQ_W-1:0] inv_sigma_sq_ff, inv_sigma_sq_in;

   // front to queue, queue to back
   push_type         close_push;
   queue_status_type queue_status;
   close_type        head;
   logic             pop;

   always_comb begin
      mode_in         = mode_ff;
      inv_sigma_sq_in = inv_sigma_sq_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_MODE:         mode_in         = csr_write_data[0];
            REG_INV_SIGMA_SQ: inv_sigma_sq_in = csr_write_data[INV_SIGMA_SQ_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_GAUSSIAN;
         inv_sigma_sq_ff <= INV_SIGMA_SQ_RESET;
      end else begin
         mode_ff         <= mode_in;
         inv_sigma_sq_ff <= inv_sigma_sq_in;
      end
   end

   // front: weight pipeline and per-set accumulation, one item per cycle while the queue has room
   gwc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .mode         (mode_ff),
      .inv_sigma_sq (inv_sigma_sq_ff),
      .queue_status (queue_status),
      .close_push   (close_push)
   );

   // closed sets waiting for the divider
   gwc_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .close_push   (close_push),
      .pop          (pop),
      .queue_status (queue_status),
      .head         (head)
   );

   // back: rounded division and result register
   gwc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head         (head),
      .pop          (pop),
      .rsp          (rsp)
   );

endmodule

`default_nettype wire
